[hdl/drht_pkg.sv]
// ----------------------------------------------------------------------------
// Damage region hit test package
// Shared constants, operation and status codes, controller/datapath
// interface structs and the one-dimensional overlap function.
// ----------------------------------------------------------------------------
package drht_pkg;

  localparam int unsigned MaxRectsDefault = 16;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned EntryW   = 4 * CoordW;
  localparam int unsigned InDataW  = 4 * CoordW;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CountW   = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // latch the accepted word
    logic apply;       // execute add, clear, an unused code or a query that needs no scan
    logic scan_start;  // reset scan index and hit flag
    logic scan_step;   // read the entry at the scan index, advance index
    logic res_load;    // move the result into the output register
  } drht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_scan;  // latched word is a query that must walk the list
    logic scan_last;   // scan index points at the last stored entry
  } drht_sts_t;

  // Half-open interval overlap test: a < b + bw and b < a + aw, formed at
  // 34 bits so that neither sum can wrap.
  function automatic logic overlap_1d(input logic signed [CoordW-1:0] a,
                                      input logic        [CoordW-1:0] aw,
                                      input logic signed [CoordW-1:0] b,
                                      input logic        [CoordW-1:0] bw);
    logic signed [CoordW+1:0] a_ext;
    logic signed [CoordW+1:0] b_ext;
    logic signed [CoordW+1:0] a_end;
    logic signed [CoordW+1:0] b_end;
    a_ext = (CoordW+2)'(a);
    b_ext = (CoordW+2)'(b);
    a_end = a_ext + $signed({2'b00, aw});
    b_end = b_ext + $signed({2'b00, bw});
    return (a_ext < b_end) && (b_ext < a_end);
  endfunction

endpackage

[hdl/drht_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/drht_dp.sv]
// ----------------------------------------------------------------------------
// Damage region datapath
// Holds the accepted word, the rectangle store, fill count, overflow mark,
// the scan index and hit flag, and the output payload register.
// ----------------------------------------------------------------------------
module drht_dp import drht_pkg::*; #(
  parameter int unsigned MAX_RECTS = MaxRectsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drht_cmd_t           cmd_i,
  output drht_sts_t           sts_o,
  input  logic [InDataW-1:0]  item_data_i,
  input  logic [1:0]          item_func_i,
  output logic [OutDataW-1:0] res_data_o
);

  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);
  localparam int unsigned IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

  logic [1:0]               func_q;
  logic signed [CoordW-1:0] x_q;
  logic signed [CoordW-1:0] y_q;
  logic [CoordW-1:0]        w_q;
  logic [CoordW-1:0]        h_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic                     rd_valid_q;
  logic [1:0]               status_q, status_d;
  logic                     hit_q, hit_d;
  logic [OutDataW-1:0]      res_q;

  logic                     empty_rect;
  logic                     full;
  logic                     ram_we;
  logic [EntryW-1:0]        ram_rdata;
  logic signed [CoordW-1:0] e_x;
  logic signed [CoordW-1:0] e_y;
  logic [CoordW-1:0]        e_w;
  logic [CoordW-1:0]        e_h;
  logic                     entry_hit;

  assign empty_rect = (w_q == '0) || (h_q == '0);
  assign full       = (count_q == CntW'(MAX_RECTS));

  assign sts_o.needs_scan = (func_q == FUNC_QUERY) && !empty_rect && !ovf_q
                            && (count_q != '0);
  assign sts_o.scan_last  = ((idx_q + CntW'(1)) == count_q);

  assign ram_we = cmd_i.apply && (func_q == FUNC_ADD) && !empty_rect && !full;

  drht_ram #(
    .Width (EntryW),
    .Depth (MAX_RECTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({h_q, w_q, y_q, x_q}),
    .re_i    (cmd_i.scan_step),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign e_x = ram_rdata[CoordW-1:0];
  assign e_y = ram_rdata[2*CoordW-1:CoordW];
  assign e_w = ram_rdata[3*CoordW-1:2*CoordW];
  assign e_h = ram_rdata[4*CoordW-1:3*CoordW];

  assign entry_hit = overlap_1d(e_x, e_w, x_q, w_q) && overlap_1d(e_y, e_h, y_q, h_q);

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    idx_d    = idx_q;
    status_d = status_q;
    hit_d    = hit_q;
    if (cmd_i.apply) begin
      status_d = STATUS_DONE;
      hit_d    = 1'b0;
      case (func_q)
        FUNC_ADD: begin
          if (empty_rect) begin
            status_d = STATUS_EMPTY;
          end else if (full) begin
            status_d = STATUS_FULL;
            ovf_d    = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        FUNC_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        FUNC_QUERY: begin
          // A non-empty query after an overflow hits without a scan.
          hit_d = !empty_rect && ovf_q;
        end
        default: begin
          status_d = STATUS_DONE;
        end
      endcase
    end
    if (cmd_i.scan_start) begin
      status_d = STATUS_DONE;
      hit_d    = 1'b0;
      idx_d    = '0;
    end
    if (cmd_i.scan_step) begin
      idx_d = idx_q + CntW'(1);
    end
    if (rd_valid_q && entry_hit) begin
      hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      rd_valid_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= item_func_i;
      x_q    <= item_data_i[CoordW-1:0];
      y_q    <= item_data_i[2*CoordW-1:CoordW];
      w_q    <= item_data_i[3*CoordW-1:2*CoordW];
      h_q    <= item_data_i[4*CoordW-1:3*CoordW];
    end
    idx_q    <= idx_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    if (cmd_i.res_load) begin
      res_q <= {(OutDataW-CountW-4)'(0), CountW'(count_q), (count_q == '0),
                hit_q, status_q};
    end
  end

  assign res_data_o = res_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RECTS))
    else $error("fill count beyond store depth");

  a_ovf_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow mark set while store not full");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !full)
    else $error("store written while full");

endmodule

[hdl/drht_ctrl.sv]
// ----------------------------------------------------------------------------
// Damage region controller
// Sequences accept, execute, list scan and result hand-off, and owns the
// input ready and output valid of the stream channels.
// ----------------------------------------------------------------------------
module drht_ctrl import drht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  drht_sts_t sts_i,
  output drht_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.needs_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The compare of the last entry read lands here.
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_scan_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |=> (state_q == S_SCAN))
    else $error("scan did not follow scan start");

  a_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

[hdl/damage_region_hit_test_top.sv]
// ----------------------------------------------------------------------------
// Damage region hit test, top level
// Keeps a bounded list of damage rectangles and answers overlap queries.
//
// Input channel s_axis: one word per operation; tuser carries the operation
// (add, clear, query), tdata the rectangle x, y, width, height.
// Output channel m_axis: one word per operation with status, hit, region
// empty flag and entry count.
// Add, clear, an unused operation and a query that needs no scan (empty
// query, overflow set or empty list) pass through execute and finish; a
// query that walks the list reads one stored entry per cycle through the
// registered read port of the rectangle RAM, then drains and finishes.
// The next word is accepted in the cycle after the result is loaded.
// A finished result waits in the output register while the next word is
// accepted and worked on; it stalls only when a second result is ready
// before the first has been taken.
// Reset empties the list and clears the overflow mark; no clearing pass.
// ----------------------------------------------------------------------------
module damage_region_hit_test_top import drht_pkg::*; #(
  parameter int unsigned MAX_RECTS = MaxRectsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] rect_x, [63:32] rect_y, [95:64] rect_width, [127:96] rect_height
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [2] hit, [3] region_empty, [8:4] entry_count, [15:9] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  drht_cmd_t cmd;
  drht_sts_t sts;

  drht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  drht_dp #(
    .MAX_RECTS (MAX_RECTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_data_i (s_axis_tdata),
    .item_func_i (s_axis_tuser),
    .res_data_o  (m_axis_tdata)
  );

endmodule

[tb/sv/damage_region_hit_test_top_tb.sv]
// ----------------------------------------------------------------------------
// Damage region hit test, self-checking testbench
// Streams add, clear and query words into the block and keeps its own copy of
// the rectangle list to predict every result word. Both stream sides idle in
// random bursts, and the receiver holds off once for a long stretch so that
// the block backs up into its input.
// ----------------------------------------------------------------------------
module damage_region_hit_test_top_tb import drht_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_RECTS   = MaxRectsDefault;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          RANDOM_OPS  = 1450;
  localparam int          QUIET_TAIL  = 150;   // words at the end sent without idling
  localparam int          HOLD_AFTER  = 300;   // results seen before the long hold-off
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 40;
  localparam int          CYCLE_LIMIT = 400000;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic        [31:0] SIZE_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        h;
    logic [31:0]        w;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } rect_op_t;

  // Same layout as the result word, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0] pad;
    logic [4:0] entry_count;
    logic       region_empty;
    logic       hit;
    logic [1:0] status;
  } region_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  damage_region_hit_test_top #(
    .MAX_RECTS(MAX_RECTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the damage list.
  logic signed [31:0] area_left   [MAX_RECTS];
  logic signed [31:0] area_top    [MAX_RECTS];
  logic        [31:0] area_width  [MAX_RECTS];
  logic        [31:0] area_height [MAX_RECTS];
  int unsigned        area_count;
  bit                 area_overflow;

  rect_op_t       rect_op_q[$];
  region_status_t region_status_q[$];

  int error_count;
  int results_seen;
  int cycle_count;
  int tx_gap_left;
  int rx_stall_left;
  int rx_hold_left;
  bit rx_hold_done;
  bit tx_busy;
  bit tx_valid_nxt;
  bit rx_ready_nxt;

  function automatic region_status_t predict_region_status(rect_op_t op);
    region_status_t res;
    bit             empty_rect;
    longint         qx;
    longint         qy;
    longint         ex;
    longint         ey;
    res        = '0;
    empty_rect = (op.w == 0) || (op.h == 0);
    qx         = longint'(op.x);
    qy         = longint'(op.y);
    case (op.func)
      FUNC_ADD: begin
        if (empty_rect) begin
          res.status = STATUS_EMPTY;
        end else if (area_count >= MAX_RECTS) begin
          res.status    = STATUS_FULL;
          area_overflow = 1'b1;
        end else begin
          area_left[area_count]   = op.x;
          area_top[area_count]    = op.y;
          area_width[area_count]  = op.w;
          area_height[area_count] = op.h;
          area_count++;
        end
      end
      FUNC_CLEAR: begin
        area_count    = 0;
        area_overflow = 1'b0;
      end
      FUNC_QUERY: begin
        if (!empty_rect) begin
          res.hit = area_overflow;
          // Half-open overlap, sums formed wide enough that nothing wraps.
          for (int i = 0; i < area_count; i++) begin
            ex = longint'(area_left[i]);
            ey = longint'(area_top[i]);
            if (ex < qx + longint'(op.w) && qx < ex + longint'(area_width[i]) &&
                ey < qy + longint'(op.h) && qy < ey + longint'(area_height[i]))
              res.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.region_empty = (area_count == 0);
    res.entry_count  = area_count[4:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0: return SIZE_MAX;
          1: return 32'h8000_0000;
          default: return 32'd1;
        endcase
      end
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  task automatic push_op(input logic [1:0] func, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] w, input logic [31:0] h);
    rect_op_t op;
    op.func = func;
    op.x    = x;
    op.y    = y;
    op.w    = w;
    op.h    = h;
    rect_op_q.insert(rect_op_q.size(), op);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Sender: presents the oldest pending word, predicts its result on accept.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        region_status_q.insert(region_status_q.size(),
                               predict_region_status(rect_op_q.pop_front()));
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          tx_valid_nxt = 1'b0;
        end else if (rect_op_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          tx_gap_left  = $urandom_range(1, 8) - 1;
          tx_valid_nxt = 1'b0;
        end else if (rect_op_q.size() != 0) begin
          tx_valid_nxt = 1'b1;
          s_axis_tdata <= {rect_op_q[0].h, rect_op_q[0].w, rect_op_q[0].y, rect_op_q[0].x};
          s_axis_tuser <= rect_op_q[0].func;
        end else begin
          tx_valid_nxt = 1'b0;
        end
        s_axis_tvalid <= tx_valid_nxt;
      end
    end
  end

  // Receiver: checks each result word and throttles tready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (region_status_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          error_count++;
        end else begin
          region_status_t exp_res;
          region_status_t got_res;
          exp_res = region_status_q.pop_front();
          got_res = m_axis_tdata;
          check_field("status", exp_res.status, got_res.status);
          check_field("hit", exp_res.hit, got_res.hit);
          check_field("region_empty", exp_res.region_empty, got_res.region_empty);
          check_field("entry_count", exp_res.entry_count, got_res.entry_count);
          check_field("pad", exp_res.pad, got_res.pad);
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rx_ready_nxt = 1'b0;
      end else if (!rx_hold_done && results_seen >= HOLD_AFTER) begin
        // One long hold-off so the block fills up and backs up the input.
        rx_hold_done = 1'b1;
        rx_hold_left = HOLD_CYCLES - 1;
        rx_ready_nxt = 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        rx_ready_nxt = 1'b0;
      end else if (rect_op_q.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(1, 8) - 1;
        rx_ready_nxt  = 1'b0;
      end else begin
        rx_ready_nxt = 1'b1;
      end
      m_axis_tready <= rx_ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          pick;
    logic [31:0] w;
    logic [31:0] h;
    area_count    = 0;
    area_overflow = 1'b0;

    // Directed: extremes, empty rectangles, edge adjacency, unused code.
    push_op(FUNC_QUERY, 32'd0, 32'd0, 32'd4, 32'd4);
    push_op(FUNC_ADD, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX);
    push_op(FUNC_ADD, COORD_MAX, COORD_MAX, 32'd1, 32'd1);
    push_op(FUNC_ADD, 32'd5, 32'd5, 32'd0, 32'd7);
    push_op(FUNC_ADD, 32'd5, 32'd5, 32'd7, 32'd0);
    push_op(FUNC_QUERY, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX);
    push_op(FUNC_QUERY, 32'd0, 32'd0, 32'd0, SIZE_MAX);
    push_op(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_MAX, SIZE_MAX);
    push_op(FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
    push_op(FUNC_ADD, 32'd0, 32'd0, 32'd10, 32'd10);
    push_op(FUNC_QUERY, 32'd10, 32'd0, 32'd5, 32'd5);
    push_op(FUNC_QUERY, 32'hFFFF_FFFB, 32'hFFFF_FFFB, 32'd5, 32'd5);
    push_op(FUNC_QUERY, 32'd9, 32'd9, SIZE_MAX, SIZE_MAX);
    // Fill the list to the top, then overrun it.
    for (int i = 1; i < MAX_RECTS; i++)
      push_op(FUNC_ADD, 32'd100 * i, 32'd100 * i, 32'd4, 32'd4);
    push_op(FUNC_ADD, 32'd0, 32'd0, 32'd1, 32'd1);
    push_op(FUNC_QUERY, 32'h4000_0000, 32'h4000_0000, 32'd1, 32'd1);
    push_op(FUNC_QUERY, 32'h4000_0000, 32'h4000_0000, 32'd0, 32'd0);
    push_op(FUNC_ADD, 32'd0, 32'd0, 32'd0, 32'd3);
    push_op(FUNC_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);

    // Random: mostly adds and queries, rare clears so the list often fills.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(0, 99);
      w    = rand_size();
      h    = rand_size();
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) w = '0;
        else h = '0;
      end
      if (pick < 3)
        push_op(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 5)
        push_op(FUNC_UNUSED, rand_coord(), rand_coord(), w, h);
      else if (pick < 50)
        push_op(FUNC_ADD, rand_coord(), rand_coord(), w, h);
      else
        push_op(FUNC_QUERY, rand_coord(), rand_coord(), w, h);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rect_op_q.size() != 0 || region_status_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (region_status_q.size() != 0) begin
      $error("%0d expected result words never arrived", region_status_q.size());
      error_count++;
    end
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/drht_pkg.sv
hdl/drht_ram.sv
hdl/drht_dp.sv
hdl/drht_ctrl.sv
hdl/damage_region_hit_test_top.sv
tb/sv/damage_region_hit_test_top_tb.sv
